FILE: hdl/hrf_pkg.sv
package hrf_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_connection;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  route;
      logic [13:0] header_length;
      logic [12:0] body_bytes;
   } rsp_type;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   localparam logic [1:0] ROUTE_NONE  = 2'd0;
   localparam logic [1:0] ROUTE_READY = 2'd1;
   localparam logic [1:0] ROUTE_FRAUD = 2'd2;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LEAD   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;

   localparam logic [4:0] KEY_DONE = 5'd15;
   localparam logic [4:0] KEY_OFF  = 5'd31;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [23:0] HDR_TAIL = 24'h0D0A0D;

   localparam logic [119:0] KEY_LOWER  = "content-length:";
   localparam logic [119:0] KEY_EXACT  = "Content-Length:";
   localparam logic [135:0] POST_ROUTE = "POST /fraud-score";
   localparam logic [79:0]  GET_ROUTE  = "GET /ready";

   function automatic logic [7:0] key_lower_char(input logic [3:0] k);
      return KEY_LOWER[{4'd14 - k, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] key_exact_char(input logic [3:0] k);
      return KEY_EXACT[{4'd14 - k, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] post_char(input logic [4:0] p);
      return POST_ROUTE[{5'd16 - p, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] get_char(input logic [3:0] p);
      return GET_ROUTE[{4'd9 - p, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? (b | 8'h20) : b;
   endfunction

endpackage

FILE: hdl/http_request_framer_unit.sv
// channel  | ports                          | direction
// ---------+--------------------------------+----------
// request  | req_valid req_stall req_data   | in
// result   | rsp_valid rsp_stall rsp_data   | out
//
// One request byte per cycle while req_stall is low; a result is registered at the edge that takes its last byte.
// Parse state sits in one register bank updated by the accepted byte.
// Reset clears all parse state and the output and skid valid flags.
// A stalled result holds in the output register; one more lands in the skid
// register, and req_stall rises only while the skid register is full.
module http_request_framer_unit #(
   parameter int BUFFER_BYTES = 8192
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  hrf_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output hrf_pkg::rsp_type rsp_data
);
   import hrf_pkg::*;

   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int VW = CW + 4;
   localparam logic [CW-1:0] BUF_LIMIT = CW'(BUFFER_BYTES);

   typedef struct packed {
      logic [CW-1:0] count;
      logic [23:0]   recent;
      logic          hdr_done;
      logic [CW-1:0] hdr_size;
      logic [4:0]    key_pos;
      logic          key_exact;
      logic [1:0]    phase;
      logic          exact_found;
      logic [CW-1:0] exact_value;
      logic          loose_found;
      logic [CW-1:0] loose_value;
      logic [1:0]    route_flags;
      logic [CW-1:0] body_count;
   } parse_state_type;

   localparam parse_state_type CLEARED = '{
      count: '0, recent: '0, hdr_done: 1'b0, hdr_size: '0, key_pos: '0,
      key_exact: 1'b1, phase: PH_IDLE, exact_found: 1'b0, exact_value: '0,
      loose_found: 1'b0, loose_value: '0, route_flags: 2'b11, body_count: '0
   };

   parse_state_type st_ff, st_in;
   logic            drop_ff, drop_in;
   rsp_type         out_ff, out_in, skid_ff, skid_in, res;
   logic            out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic            res_valid, req_fire, complete;
   logic [CW-1:0]   pos, val, target;
   logic [VW-1:0]   prod;
   logic [7:0]      b, prev;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign b         = req_data.data_byte;

   always_comb begin
      st_in     = st_ff;
      drop_in   = drop_ff;
      res_valid = 1'b0;
      res       = '0;
      complete  = 1'b0;
      pos       = '0;
      val       = '0;
      prod      = '0;
      target    = '0;
      prev      = '0;
      if (req_fire) begin
         if (req_data.new_connection) begin
            st_in   = CLEARED;
            drop_in = 1'b0;
         end
         if (!drop_in) begin
            pos = st_in.count;
            if (pos < CW'(17)) begin
               if (b != post_char(pos[4:0])) st_in.route_flags[0] = 1'b0;
            end else if (pos == CW'(17)) begin
               if (b != CH_SPACE && b != CH_QUERY) st_in.route_flags[0] = 1'b0;
            end
            if (pos < CW'(10)) begin
               if (b != get_char(pos[3:0])) st_in.route_flags[1] = 1'b0;
            end else if (pos == CW'(10)) begin
               if (b != CH_SPACE && b != CH_QUERY) st_in.route_flags[1] = 1'b0;
            end
            st_in.count = pos + CW'(1);

            if (!st_in.hdr_done) begin
               prev = st_in.recent[7:0];
               if (st_in.phase != PH_IDLE) begin
                  val = st_in.key_exact ? st_in.exact_value : st_in.loose_value;
                  if (b == CH_SPACE || b == CH_TAB) begin
                     if (st_in.phase == PH_DIGITS) st_in.phase = PH_IDLE;
                  end else if (b < CH_ZERO || b > CH_NINE) begin
                     st_in.phase = PH_IDLE;
                  end else begin
                     st_in.phase = PH_DIGITS;
                     prod = (VW'(val) << 3) + (VW'(val) << 1) + VW'(b[3:0]);
                     if (prod > VW'(BUFFER_BYTES)) val = BUF_LIMIT;
                     else val = prod[CW-1:0];
                     if (st_in.key_exact) st_in.exact_value = val;
                     else st_in.loose_value = val;
                  end
               end else if (st_in.key_pos < KEY_DONE) begin
                  if (to_lower(b) != key_lower_char(st_in.key_pos[3:0])) begin
                     st_in.key_pos = KEY_OFF;
                  end else begin
                     if (b != key_exact_char(st_in.key_pos[3:0])) st_in.key_exact = 1'b0;
                     st_in.key_pos = st_in.key_pos + 5'd1;
                     if (st_in.key_pos == KEY_DONE) begin
                        if (st_in.key_exact && !st_in.exact_found) begin
                           st_in.exact_found = 1'b1;
                           st_in.exact_value = '0;
                           st_in.phase       = PH_LEAD;
                        end else if (!st_in.key_exact && !st_in.loose_found) begin
                           st_in.loose_found = 1'b1;
                           st_in.loose_value = '0;
                           st_in.phase       = PH_LEAD;
                        end
                     end
                  end
               end
               if (prev == CH_CR && b == CH_LF) begin
                  st_in.key_pos   = '0;
                  st_in.key_exact = 1'b1;
               end
               target = st_in.exact_found ? st_in.exact_value :
                        st_in.loose_found ? st_in.loose_value : '0;
               if (st_in.recent == HDR_TAIL && b == CH_LF) begin
                  st_in.hdr_done = 1'b1;
                  st_in.hdr_size = st_in.count;
                  st_in.phase    = PH_IDLE;
                  if (target == '0) complete = 1'b1;
               end
               st_in.recent = {st_in.recent[15:0], b};
            end else begin
               target = st_in.exact_found ? st_in.exact_value :
                        st_in.loose_found ? st_in.loose_value : '0;
               st_in.body_count = st_in.body_count + CW'(1);
               if (st_in.body_count >= target) complete = 1'b1;
            end

            if (complete) begin
               res_valid         = 1'b1;
               res.status        = STATUS_DONE;
               if (st_in.route_flags[0] && st_in.count >= CW'(18)) res.route = ROUTE_FRAUD;
               else if (st_in.route_flags[1] && st_in.count >= CW'(11)) res.route = ROUTE_READY;
               else res.route = ROUTE_NONE;
               res.header_length = 14'(st_in.hdr_size);
               res.body_bytes    = 13'(target);
               st_in             = CLEARED;
            end else if (st_in.count >= BUF_LIMIT) begin
               res_valid  = 1'b1;
               res.status = STATUS_OVERFLOW;
               st_in      = CLEARED;
               drop_in    = 1'b1;
            end
         end
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= CLEARED;
         drop_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         drop_ff       <= drop_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: hdl/hrf_checker.sv
module hrf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input hrf_pkg::rsp_type rsp_data
);
   import hrf_pkg::*;

   // stalled result must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OVERFLOW |->
         rsp_data.route == ROUTE_NONE && rsp_data.header_length == 14'd0 &&
         rsp_data.body_bytes == 13'd0)
      else $error("overflow result carries fields");

   a_route_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.route == ROUTE_NONE || rsp_data.route == ROUTE_READY ||
         rsp_data.route == ROUTE_FRAUD)
      else $error("bad route code");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && $past(rsp_valid))
      else $error("request stalled with no result pending");

endmodule

bind http_request_framer_unit hrf_checker u_hrf_checker (.*);
